### sv/harmonic_cv_restraint_force_unit_assert.svh
// Assertion macros used by the checker module hcrf_check.
`ifndef HARMONIC_CV_RESTRAINT_FORCE_UNIT_ASSERT_SVH
`define HARMONIC_CV_RESTRAINT_FORCE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HCRF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HCRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hcrf_pkg.sv
`default_nettype none
package hcrf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int STEP_W      = 31;
    localparam int VAL_W       = 32;
    localparam int DEV_W       = 33;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 352;
    localparam int OUT_TDATA_W = 160;
    localparam int SCALE_LAT   = 4;
    localparam int SKID_DEPTH  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_WEIGHT     = 3'd0,
        REG_REFERENCE_VALUE = 3'd1,
        REG_PERIOD_LENGTH   = 3'd2,
        REG_START_STEP      = 3'd3,
        REG_RAMP_END_STEP   = 3'd4,
        REG_FADE_START_STEP = 3'd5,
        REG_STOP_STEP       = 3'd6
    } cfg_reg_t;

endpackage
`default_nettype wire

### sv/hcrf_div.sv
`default_nettype none
module hcrf_div
    import hcrf_pkg::*;
#(
    parameter int DW = 31,
    parameter int QW = 31
)
(
    input  wire          clk,
    input  wire          en,
    input  wire [DW-1:0] rem_in,
    input  wire [QW-1:0] num_in,
    input  wire [DW-1:0] den_in,
    output logic [QW-1:0] quot,
    output logic [DW-1:0] rem
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] nq_reg  [QW];
    logic [DW-1:0] den_reg [QW];

    logic [DW-1:0] src_rem  [QW];
    logic [QW-1:0] src_nq   [QW];
    logic [DW-1:0] src_den  [QW];
    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] nq_next  [QW];
    logic [DW:0]   trial    [QW];
    logic [DW:0]   diff     [QW];
    logic          ge       [QW];

    always_comb
    begin
        src_rem[0] = rem_in;
        src_nq[0]  = num_in;
        src_den[0] = den_in;
        for (int k = 1; k < QW; k++)
        begin
            src_rem[k] = rem_reg[k-1];
            src_nq[k]  = nq_reg[k-1];
            src_den[k] = den_reg[k-1];
        end
        for (int k = 0; k < QW; k++)
        begin
            trial[k]    = {src_rem[k], src_nq[k][QW-1]};
            diff[k]     = trial[k] - {1'b0, src_den[k]};
            ge[k]       = trial[k] >= {1'b0, src_den[k]};
            rem_next[k] = ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
            nq_next[k]  = {src_nq[k][QW-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k] <= rem_next[k];
                nq_reg[k]  <= nq_next[k];
                den_reg[k] <= src_den[k];
            end
        end
    end

    assign quot = nq_reg[QW-1];
    assign rem  = rem_reg[QW-1];

endmodule
`default_nettype wire

### sv/hcrf_scale.sv
`default_nettype none
module hcrf_scale
    import hcrf_pkg::*;
#(
    parameter int BW    = 49,
    parameter int SHIFT = 32
)
(
    input  wire                 clk,
    input  wire                 en,
    input  wire [62:0]          a,
    input  wire [BW-1:0]        b,
    input  wire                 neg,
    output logic [VAL_W-1:0]    res
);

    localparam int PW = 63 + BW;
    localparam int QN = PW - SHIFT;

    logic [63:0]      pp00_reg;
    logic [BW-1:0]    pp01_reg;
    logic [62:0]      pp10_reg;
    logic [BW-2:0]    pp11_reg;
    logic             neg1_reg;
    logic [63:0]      mid_reg;
    logic [63:0]      lo_reg;
    logic [BW-2:0]    hi_reg;
    logic             neg2_reg;
    logic [PW-1:0]    prod_reg;
    logic             neg3_reg;
    logic [VAL_W-1:0] res_reg;

    logic [PW-1:0]    prod_next;
    logic [QN-1:0]    q;
    logic [VAL_W-1:0] limit;
    logic [VAL_W-1:0] mag;
    logic             over;
    logic [VAL_W-1:0] res_next;

    always_comb
    begin
        prod_next = {hi_reg, lo_reg} + (PW'(mid_reg) << 32);
        q         = prod_reg[PW-1:SHIFT];
        limit     = neg3_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        over      = (|q[QN-1:VAL_W]) || (q[VAL_W-1:0] > limit);
        mag       = over ? limit : q[VAL_W-1:0];
        res_next  = neg3_reg ? (~mag + 32'd1) : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= a[31:0] * b[31:0];
            pp01_reg <= a[31:0] * b[BW-1:32];
            pp10_reg <= a[62:32] * b[31:0];
            pp11_reg <= a[62:32] * b[BW-1:32];
            neg1_reg <= neg;
            mid_reg  <= 64'(pp01_reg) + 64'(pp10_reg);
            lo_reg   <= pp00_reg;
            hi_reg   <= pp11_reg;
            neg2_reg <= neg1_reg;
            prod_reg <= prod_next;
            neg3_reg <= neg2_reg;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

### sv/harmonic_cv_restraint_force_unit.sv
`default_nettype none
// Throughput: one item per cycle while the output buffer is not full; depth is set
// by the two 31-step ramp dividers in series, with the 35-step wrap divider
// running beside the first.
// A 2-entry output buffer holds results; the pipeline stalls only when it is full.
// Reset clears all configuration registers, valid bits and the buffer count.
module harmonic_cv_restraint_force_unit
    import hcrf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // step_number, cv_sample, grad_x, grad_y, grad_z, box_grad_x, box_grad_y,
    // box_grad_z, box_len_x, box_len_y, box_len_z, zero pad
    input  wire [IN_TDATA_W-1:0]   s_tdata,
    input  wire                    s_tlast,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // restraint_energy, force_x, force_y, force_z, virial_term
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // active
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam int PROD_W    = 2 * VAL_W - 1;
    localparam int DOT_SUM_W = PROD_W + 2;
    localparam int DOT_W     = DOT_SUM_W - FRAC_BITS;
    localparam int NUM_W     = 2 * STEP_W;
    localparam int WD_W      = STEP_W + VAL_W;
    localparam int X_W       = DEV_W + 2;
    localparam int RAMP_QW   = STEP_W;
    localparam int WRAP_QW   = X_W;
    localparam int ST_PRE    = 1;
    localparam int ST_DOT    = 2;
    localparam int W1_ST     = ST_PRE + RAMP_QW;
    localparam int ST_FADE   = W1_ST + 1;
    localparam int W2_ST     = ST_FADE + RAMP_QW;
    localparam int WRAP_ST   = ST_PRE + WRAP_QW;
    localparam int ST_WDEV   = WRAP_ST + 1;
    localparam int ST_WD     = W2_ST + 1;
    localparam int ST_OUT    = ST_WD + SCALE_LAT;
    localparam int CNT_W     = $clog2(SKID_DEPTH + 1);
    localparam int SEL_W     = $clog2(SKID_DEPTH);

    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic                      active;
        logic                      fade;
        logic [STEP_W-1:0]         smst;
        logic                      xneg;
        logic signed [DEV_W-1:0]   dev;
        logic signed [VAL_W-1:0]   gx;
        logic signed [VAL_W-1:0]   gy;
        logic signed [VAL_W-1:0]   gz;
        logic signed [DOT_W-1:0]   dot;
    } side_t;

    typedef struct packed {
        logic [VAL_W-1:0] energy;
        logic [VAL_W-1:0] fx;
        logic [VAL_W-1:0] fy;
        logic [VAL_W-1:0] fz;
        logic [VAL_W-1:0] vir;
        logic             active;
        logic             last;
    } res_t;

    logic [STEP_W-1:0] base_weight_reg;
    logic [VAL_W-1:0]  reference_value_reg;
    logic [STEP_W-1:0] period_length_reg;
    logic [STEP_W-1:0] start_step_reg;
    logic [STEP_W-1:0] ramp_end_step_reg;
    logic [STEP_W-1:0] fade_start_step_reg;
    logic [STEP_W-1:0] stop_step_reg;

    logic en;

    side_t side_reg  [ST_OUT+1];
    side_t side_next [ST_OUT+1];

    logic [STEP_W-1:0] step0_reg;
    logic [VAL_W-1:0]  cv0_reg;
    logic [VAL_W-1:0]  bg0_reg [3];
    logic [STEP_W-1:0] bl0_reg [3];

    logic [STEP_W-1:0]        step_off;
    logic                     act1;
    logic                     ramp1;
    logic                     fade1;
    logic [NUM_W-1:0]         num1_next;
    logic [STEP_W-1:0]        den1_next;
    logic signed [DEV_W-1:0]  dev1;
    logic signed [X_W-1:0]    x1;
    logic [X_W-1:0]           xmag1;
    logic signed [PROD_W-1:0] p_next [3];

    logic [NUM_W-1:0]         num1_reg;
    logic [STEP_W-1:0]        den1_reg;
    logic [X_W-1:0]           xmag1_reg;
    logic signed [PROD_W-1:0] p_reg [3];

    logic signed [DOT_SUM_W-1:0] dot_sum;

    logic [STEP_W-1:0] w1;
    logic [NUM_W-1:0]  num2_next;
    logic [STEP_W-1:0] den2_next;
    logic [NUM_W-1:0]  num2_reg;
    logic [STEP_W-1:0] den2_reg;
    logic [STEP_W-1:0] w2;

    logic [VAL_W-1:0]  wrap_rem;
    logic [VAL_W-1:0]  wrap_den;
    logic [VAL_W-1:0]  wrap_r;
    logic [DEV_W-1:0]  wrap_diff;
    logic signed [DEV_W-1:0] dev_wrapped;

    logic [DEV_W-1:0]  dmag_w2;
    logic [WD_W-1:0]   wd_reg;

    logic [DEV_W-1:0]  dmag_o;
    logic              dneg_o;
    logic [VAL_W-1:0]  gxmag;
    logic [VAL_W-1:0]  gymag;
    logic [VAL_W-1:0]  gzmag;
    logic [DOT_W-1:0]  dotmag;
    logic [VAL_W-1:0]  e_res;
    logic [VAL_W-1:0]  fx_res;
    logic [VAL_W-1:0]  fy_res;
    logic [VAL_W-1:0]  fz_res;
    logic [VAL_W-1:0]  vir_res;

    res_t             ent_reg  [SKID_DEPTH];
    res_t             ent_next [SKID_DEPTH];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] fill;
    logic [SEL_W-1:0] wr_idx;
    logic             push;
    logic             pop;
    res_t             res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_weight_reg     <= '0;
            reference_value_reg <= '0;
            period_length_reg   <= '0;
            start_step_reg      <= '0;
            ramp_end_step_reg   <= '0;
            fade_start_step_reg <= '0;
            stop_step_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BASE_WEIGHT:     base_weight_reg     <= cfg_data[STEP_W-1:0];
                REG_REFERENCE_VALUE: reference_value_reg <= cfg_data[VAL_W-1:0];
                REG_PERIOD_LENGTH:   period_length_reg   <= cfg_data[STEP_W-1:0];
                REG_START_STEP:      start_step_reg      <= cfg_data[STEP_W-1:0];
                REG_RAMP_END_STEP:   ramp_end_step_reg   <= cfg_data[STEP_W-1:0];
                REG_FADE_START_STEP: fade_start_step_reg <= cfg_data[STEP_W-1:0];
                REG_STOP_STEP:       stop_step_reg       <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign en       = cnt_reg != CNT_W'(SKID_DEPTH);
    assign s_tready = en;

    always_comb
    begin
        step_off  = step0_reg - start_step_reg;
        act1      = (step0_reg >= start_step_reg)
                    && ((stop_step_reg == '0) || (step0_reg < stop_step_reg));
        ramp1     = (step0_reg < ramp_end_step_reg) && (ramp_end_step_reg > start_step_reg);
        fade1     = (fade_start_step_reg != '0) && (step0_reg > fade_start_step_reg)
                    && (fade_start_step_reg < stop_step_reg);
        num1_next = ramp1 ? base_weight_reg * step_off : NUM_W'(base_weight_reg);
        den1_next = ramp1 ? (ramp_end_step_reg - start_step_reg) : STEP_W'(1);
        dev1      = {cv0_reg[VAL_W-1], cv0_reg}
                    - {reference_value_reg[VAL_W-1], reference_value_reg};
        x1        = {dev1[DEV_W-1], dev1, 1'b0} + {4'b0, period_length_reg};
        xmag1     = x1[X_W-1] ? X_W'(-x1) : X_W'(x1);
        for (int k = 0; k < 3; k++)
        begin
            p_next[k] = $signed(bg0_reg[k]) * $signed({1'b0, bl0_reg[k]});
        end
    end

    always_comb
    begin
        dot_sum = DOT_SUM_W'(p_reg[0]) + DOT_SUM_W'(p_reg[1]) + DOT_SUM_W'(p_reg[2]);
    end

    hcrf_div #(
        .DW (STEP_W),
        .QW (RAMP_QW)
    ) u_ramp_div (
        .clk    (clk),
        .en     (en),
        .rem_in (num1_reg[NUM_W-1:RAMP_QW]),
        .num_in (num1_reg[RAMP_QW-1:0]),
        .den_in (den1_reg),
        .quot   (w1),
        .rem    ()
    );

    assign wrap_den = {period_length_reg, 1'b0};

    hcrf_div #(
        .DW (VAL_W),
        .QW (WRAP_QW)
    ) u_wrap_div (
        .clk    (clk),
        .en     (en),
        .rem_in ('0),
        .num_in (xmag1_reg),
        .den_in (wrap_den),
        .quot   (),
        .rem    (wrap_rem)
    );

    always_comb
    begin
        num2_next = side_reg[W1_ST].fade ? w1 * side_reg[W1_ST].smst : NUM_W'(w1);
        den2_next = side_reg[W1_ST].fade ? (stop_step_reg - fade_start_step_reg)
                                         : STEP_W'(1);
    end

    hcrf_div #(
        .DW (STEP_W),
        .QW (RAMP_QW)
    ) u_fade_div (
        .clk    (clk),
        .en     (en),
        .rem_in (num2_reg[NUM_W-1:RAMP_QW]),
        .num_in (num2_reg[RAMP_QW-1:0]),
        .den_in (den2_reg),
        .quot   (w2),
        .rem    ()
    );

    always_comb
    begin
        wrap_r      = (side_reg[WRAP_ST].xneg && (wrap_rem != '0)) ? (wrap_den - wrap_rem)
                                                                   : wrap_rem;
        wrap_diff   = {1'b0, wrap_r} - {2'b0, period_length_reg};
        dev_wrapped = {wrap_diff[DEV_W-1], wrap_diff[DEV_W-1:1]};
        dmag_w2     = side_reg[W2_ST].dev[DEV_W-1] ? DEV_W'(-side_reg[W2_ST].dev)
                                                   : DEV_W'(side_reg[W2_ST].dev);
    end

    always_comb
    begin
        side_next[0]       = '0;
        side_next[0].valid = s_tvalid;
        side_next[0].last  = s_tlast;
        side_next[0].gx    = s_tdata[94:63];
        side_next[0].gy    = s_tdata[126:95];
        side_next[0].gz    = s_tdata[158:127];
        for (int k = 1; k <= ST_OUT; k++)
        begin
            side_next[k] = side_reg[k-1];
        end
        side_next[ST_PRE].active = act1;
        side_next[ST_PRE].fade   = fade1;
        side_next[ST_PRE].smst   = stop_step_reg - step0_reg;
        side_next[ST_PRE].dev    = dev1;
        side_next[ST_PRE].xneg   = x1[X_W-1];
        side_next[ST_DOT].dot    = dot_sum[DOT_SUM_W-1:FRAC_BITS];
        if (period_length_reg != '0)
        begin
            side_next[ST_WDEV].dev = dev_wrapped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ST_OUT; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k <= ST_OUT; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step0_reg  <= s_tdata[30:0];
            cv0_reg    <= s_tdata[62:31];
            bg0_reg[0] <= s_tdata[190:159];
            bg0_reg[1] <= s_tdata[222:191];
            bg0_reg[2] <= s_tdata[254:223];
            bl0_reg[0] <= s_tdata[285:255];
            bl0_reg[1] <= s_tdata[316:286];
            bl0_reg[2] <= s_tdata[347:317];
            num1_reg   <= num1_next;
            den1_reg   <= den1_next;
            xmag1_reg  <= xmag1;
            for (int k = 0; k < 3; k++)
            begin
                p_reg[k] <= p_next[k];
            end
            num2_reg   <= num2_next;
            den2_reg   <= den2_next;
            wd_reg     <= w2 * dmag_w2;
        end
    end

    always_comb
    begin
        dneg_o = side_reg[ST_WD].dev[DEV_W-1];
        dmag_o = dneg_o ? DEV_W'(-side_reg[ST_WD].dev) : DEV_W'(side_reg[ST_WD].dev);
        gxmag  = side_reg[ST_WD].gx[VAL_W-1] ? VAL_W'(-side_reg[ST_WD].gx)
                                             : VAL_W'(side_reg[ST_WD].gx);
        gymag  = side_reg[ST_WD].gy[VAL_W-1] ? VAL_W'(-side_reg[ST_WD].gy)
                                             : VAL_W'(side_reg[ST_WD].gy);
        gzmag  = side_reg[ST_WD].gz[VAL_W-1] ? VAL_W'(-side_reg[ST_WD].gz)
                                             : VAL_W'(side_reg[ST_WD].gz);
        dotmag = side_reg[ST_WD].dot[DOT_W-1] ? DOT_W'(-side_reg[ST_WD].dot)
                                              : DOT_W'(side_reg[ST_WD].dot);
    end

    hcrf_scale #(.BW (DOT_W), .SHIFT (2 * FRAC_BITS)) u_energy (
        .clk (clk),
        .en  (en),
        .a   (wd_reg),
        .b   (DOT_W'(dmag_o)),
        .neg (1'b0),
        .res (e_res)
    );

    hcrf_scale #(.BW (DOT_W), .SHIFT (2 * FRAC_BITS - 1)) u_force_x (
        .clk (clk),
        .en  (en),
        .a   (wd_reg),
        .b   (DOT_W'(gxmag)),
        .neg (dneg_o == side_reg[ST_WD].gx[VAL_W-1]),
        .res (fx_res)
    );

    hcrf_scale #(.BW (DOT_W), .SHIFT (2 * FRAC_BITS - 1)) u_force_y (
        .clk (clk),
        .en  (en),
        .a   (wd_reg),
        .b   (DOT_W'(gymag)),
        .neg (dneg_o == side_reg[ST_WD].gy[VAL_W-1]),
        .res (fy_res)
    );

    hcrf_scale #(.BW (DOT_W), .SHIFT (2 * FRAC_BITS - 1)) u_force_z (
        .clk (clk),
        .en  (en),
        .a   (wd_reg),
        .b   (DOT_W'(gzmag)),
        .neg (dneg_o == side_reg[ST_WD].gz[VAL_W-1]),
        .res (fz_res)
    );

    hcrf_scale #(.BW (DOT_W), .SHIFT (2 * FRAC_BITS - 1)) u_virial (
        .clk (clk),
        .en  (en),
        .a   (wd_reg),
        .b   (dotmag),
        .neg (dneg_o == side_reg[ST_WD].dot[DOT_W-1]),
        .res (vir_res)
    );

    always_comb
    begin
        res_c.active = side_reg[ST_OUT].active;
        res_c.last   = side_reg[ST_OUT].last;
        res_c.energy = side_reg[ST_OUT].active ? e_res   : '0;
        res_c.fx     = side_reg[ST_OUT].active ? fx_res  : '0;
        res_c.fy     = side_reg[ST_OUT].active ? fy_res  : '0;
        res_c.fz     = side_reg[ST_OUT].active ? fz_res  : '0;
        res_c.vir    = side_reg[ST_OUT].active ? vir_res : '0;
        push         = en && side_reg[ST_OUT].valid;
        pop          = (cnt_reg != '0) && m_tready;
        fill         = cnt_reg - CNT_W'(pop);
        wr_idx       = fill[SEL_W-1:0];
        cnt_next     = cnt_reg + CNT_W'(push) - CNT_W'(pop);
        for (int k = 0; k < SKID_DEPTH; k++)
        begin
            ent_next[k] = ent_reg[k];
        end
        if (pop)
        begin
            for (int k = 0; k < SKID_DEPTH - 1; k++)
            begin
                ent_next[k] = ent_reg[k+1];
            end
        end
        if (push)
        begin
            ent_next[wr_idx] = res_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SKID_DEPTH; k++)
        begin
            ent_reg[k] <= ent_next[k];
        end
    end

    assign m_tvalid = cnt_reg != '0;
    assign m_tdata  = {ent_reg[0].vir, ent_reg[0].fz, ent_reg[0].fy, ent_reg[0].fx,
                       ent_reg[0].energy};
    assign m_tuser  = ent_reg[0].active;
    assign m_tlast  = ent_reg[0].last;

endmodule
`default_nettype wire

### sv/hcrf_check.sv
`default_nettype none
`include "harmonic_cv_restraint_force_unit_assert.svh"
module hcrf_check
    import hcrf_pkg::*;
(
    input wire                   clk,
    input wire                   rst_n,
    input wire                   s_tready,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [OUT_TDATA_W-1:0] m_tdata,
    input wire                   m_tuser
);

    `HCRF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output transfer changed while stalled")
    `HCRF_ASSERT_SAME(a_empty_ready, !m_tvalid, s_tready, "input not ready with empty output buffer")
    `HCRF_ASSERT_SAME(a_inactive_zero, m_tvalid && !m_tuser, m_tdata == '0, "inactive result carries nonzero data")
    `HCRF_ASSERT_SAME(a_energy_sign, m_tvalid, !m_tdata[VAL_W-1], "negative restraint energy")

endmodule

bind harmonic_cv_restraint_force_unit hcrf_check u_hcrf_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import hcrf_pkg::*;

    localparam int FB         = 16;
    localparam int LATENCY    = 70;
    localparam int CYCLE_CAP  = 400000;

    typedef struct {
        logic [30:0] step_number;
        logic [31:0] cv_sample;
        logic [31:0] grad [3];
        logic [31:0] box_grad [3];
        logic [30:0] box_len [3];
        logic        last_atom;
    } atom_item_t;

    typedef struct {
        logic [31:0] energy;
        logic [31:0] force_v [3];
        logic [31:0] virial;
        logic        active;
        logic        last_out;
    } restraint_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_tvalid;
    wire  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic s_tlast;
    wire  m_tvalid;
    logic m_tready;
    wire  [OUT_TDATA_W-1:0] m_tdata;
    wire  m_tuser;
    wire  m_tlast;

    logic [30:0] w_base, w_period, w_start, w_ramp, w_fade, w_stop;
    logic [31:0] w_ref;

    restraint_t pending_results[$];
    int error_count;
    int cycle_count;
    int sent_count;
    int result_count;
    int active_count;
    int idle_mode;

    harmonic_cv_restraint_force_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] scale_sat(logic [63:0] a, logic [63:0] b, bit neg, int s);
        logic [127:0] pr;
        logic [127:0] lim;
        logic [31:0] r;
        pr = {64'd0, a} * {64'd0, b};
        pr = pr >> s;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (pr > lim)
            pr = lim;
        r = pr[31:0];
        return neg ? (32'd0 - r) : r;
    endfunction

    function automatic restraint_t compute_restraint(atom_item_t it);
        restraint_t res;
        logic [63:0] st, w, dmag, wd, gmag, dmagq;
        longint d, pl, num, den, n, g;
        logic signed [79:0] g80, l80, psum, dot80;
        bit dneg, dotneg;
        res.energy = 32'd0;
        res.virial = 32'd0;
        for (int i = 0; i < 3; i++)
            res.force_v[i] = 32'd0;
        res.active = 1'b0;
        res.last_out = it.last_atom;
        st = 64'(it.step_number);
        if (st < w_start || (w_stop != 0 && st >= w_stop))
            return res;
        res.active = 1'b1;
        w = 64'(w_base);
        if (st < w_ramp && w_ramp > w_start)
            w = w * (st - w_start) / (64'(w_ramp) - w_start);
        if (w_fade != 0 && st > w_fade && w_fade < w_stop)
            w = w * (64'(w_stop) - st) / (64'(w_stop) - w_fade);
        d = longint'($signed(it.cv_sample)) - longint'($signed(w_ref));
        pl = longint'(w_period);
        if (pl > 0)
        begin
            num = 2 * d + pl;
            den = 2 * pl;
            n = (num >= 0) ? num / den : -((-num + den - 1) / den);
            d = d - n * pl;
        end
        dneg = d < 0;
        dmag = dneg ? -d : d;
        wd = w * dmag;
        res.energy = scale_sat(wd, dmag, 1'b0, 2 * FB);
        for (int i = 0; i < 3; i++)
        begin
            g = longint'($signed(it.grad[i]));
            gmag = (g < 0) ? -g : g;
            res.force_v[i] = scale_sat(wd, gmag, dneg == (g < 0), 2 * FB - 1);
        end
        psum = 0;
        for (int i = 0; i < 3; i++)
        begin
            g80 = 80'($signed(it.box_grad[i]));
            l80 = 80'(it.box_len[i]);
            psum = psum + g80 * l80;
        end
        dot80 = psum >>> FB;
        dotneg = dot80 < 0;
        dmagq = dotneg ? 64'(-dot80) : 64'(dot80);
        res.virial = scale_sat(wd, dmagq, dneg == dotneg, 2 * FB - 1);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        restraint_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            else
            begin
                e = pending_results.pop_front();
                if (m_tdata[31:0] !== e.energy)
                    report_mismatch("energy", m_tdata[31:0], e.energy);
                for (int i = 0; i < 3; i++)
                    if (m_tdata[32*(i+1) +: 32] !== e.force_v[i])
                        report_mismatch($sformatf("force[%0d]", i),
                                        m_tdata[32*(i+1) +: 32], e.force_v[i]);
                if (m_tdata[159:128] !== e.virial)
                    report_mismatch("virial", m_tdata[159:128], e.virial);
                if (m_tuser !== e.active)
                    report_mismatch("active", 32'(m_tuser), 32'(e.active));
                if (m_tlast !== e.last_out)
                    report_mismatch("last", 32'(m_tlast), 32'(e.last_out));
            end
        end
    end

    always @(negedge clk)
    begin
        case (idle_mode)
            0: m_tready = ($urandom_range(99) >= 47);
            1: m_tready = ($urandom_range(99) >= 36);
            default: m_tready = 1'b1;
        endcase
    end

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            REG_BASE_WEIGHT:     w_base = value[30:0];
            REG_REFERENCE_VALUE: w_ref = value;
            REG_PERIOD_LENGTH:   w_period = value[30:0];
            REG_START_STEP:      w_start = value[30:0];
            REG_RAMP_END_STEP:   w_ramp = value[30:0];
            REG_FADE_START_STEP: w_fade = value[30:0];
            default:             w_stop = value[30:0];
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_settings(logic [30:0] base, logic [31:0] refv, logic [30:0] period,
                                 logic [30:0] start, logic [30:0] ramp, logic [30:0] fade,
                                 logic [30:0] stop);
        wait_drained();
        write_reg(REG_BASE_WEIGHT, {1'b0, base});
        write_reg(REG_REFERENCE_VALUE, refv);
        write_reg(REG_PERIOD_LENGTH, {1'b0, period});
        write_reg(REG_START_STEP, {1'b0, start});
        write_reg(REG_RAMP_END_STEP, {1'b0, ramp});
        write_reg(REG_FADE_START_STEP, {1'b0, fade});
        write_reg(REG_STOP_STEP, {1'b0, stop});
    endtask

    task automatic send_atom(atom_item_t it);
        @(negedge clk);
        if (idle_mode == 0 || idle_mode == 1)
        begin
            while ($urandom_range(99) < (idle_mode == 0 ? 36 : 47))
            begin
                s_tvalid = 1'b0;
                @(negedge clk);
            end
        end
        s_tvalid = 1'b1;
        s_tlast = it.last_atom;
        s_tdata = '0;
        s_tdata[30:0] = it.step_number;
        s_tdata[62:31] = it.cv_sample;
        for (int i = 0; i < 3; i++)
        begin
            s_tdata[63 + 32*i +: 32] = it.grad[i];
            s_tdata[159 + 32*i +: 32] = it.box_grad[i];
            s_tdata[255 + 31*i +: 31] = it.box_len[i];
        end
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(compute_restraint(it));
        sent_count++;
        if (pending_results[$].active)
            active_count++;
    endtask

    task automatic release_bus();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(2000) - 1000;
            2: return 32'($signed($urandom_range(16'hFFFF)) << $urandom_range(16));
            3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(32'h3_FFFF)) - 32'sh2_0000);
        endcase
    endfunction

    function automatic logic [30:0] pick_step();
        logic [30:0] anchor;
        int off;
        case ($urandom_range(5))
            0: anchor = w_start;
            1: anchor = w_ramp;
            2: anchor = w_fade;
            3: anchor = w_stop;
            4: return 31'($urandom);
            default: anchor = w_start + ($urandom_range(1) ? (w_stop - w_start) / 2 : 31'd0);
        endcase
        off = $urandom_range(12) - 6;
        return anchor + 31'(off);
    endfunction

    function automatic atom_item_t random_atom();
        atom_item_t it;
        it.step_number = pick_step();
        it.cv_sample = $urandom_range(3) == 0 ? $urandom : w_ref + pick_value();
        for (int i = 0; i < 3; i++)
        begin
            it.grad[i] = pick_value();
            it.box_grad[i] = pick_value();
            it.box_len[i] = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(32'h40_0000));
        end
        it.last_atom = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic test_directed();
        atom_item_t it;
        logic [31:0] ext [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        load_settings(31'h7FFF_FFFF, 32'h0000_0000, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
        for (int k = 0; k < 8; k++)
        begin
            it.step_number = (k & 1) ? 31'h7FFF_FFFF : 31'd0;
            it.cv_sample = ext[k % 4];
            for (int i = 0; i < 3; i++)
            begin
                it.grad[i] = ext[(k + i) % 4];
                it.box_grad[i] = ext[(k + i + 1) % 4];
                it.box_len[i] = (k & 2) ? 31'h7FFF_FFFF : 31'd0;
            end
            it.last_atom = k[0];
            send_atom(it);
        end
        release_bus();
        load_settings(31'h0001_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'd10, 31'd20, 31'd30,
                      31'd40);
        for (int k = 0; k < 12; k++)
        begin
            it = random_atom();
            it.step_number = 31'(5 + 4 * k);
            it.cv_sample = ext[k % 4];
            send_atom(it);
        end
        release_bus();
        load_settings(31'h0002_0000, 32'h7FFF_FFFF, 31'd1, 31'd50, 31'd50, 31'd0, 31'd0);
        for (int k = 0; k < 4; k++)
        begin
            it = random_atom();
            it.step_number = 31'(48 + k);
            send_atom(it);
        end
        release_bus();
    endtask

    task automatic test_random_phase(int count, bit hold_mid);
        for (int k = 0; k < count; k++)
        begin
            if (hold_mid && k == count / 2)
            begin
                release_bus();
                wait_drained();
            end
            send_atom(random_atom());
        end
        release_bus();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 9; ph++)
        begin
            idle_mode = ph / 3;
            case (ph)
                0: load_settings(31'h0001_8000, 32'h0003_0000, 31'd0, 31'd100, 31'd110,
                                 31'd150, 31'd160);
                1: load_settings(31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'd0,
                                 31'h7FFF_FFFF, 31'h7FFF_FFFE, 31'h7FFF_FFFF);
                2: load_settings(31'h0000_4000, 32'hFFFF_0000, 31'h0006_487F, 31'd7, 31'd3,
                                 31'd20, 31'd12);
                3: load_settings(31'd0, 32'h7FFF_FFFF, 31'd1, 31'd0, 31'd0, 31'd0, 31'd0);
                4: load_settings(31'($urandom), $urandom, 31'($urandom_range(32'h20_0000)),
                                 31'd1000, 31'd1013, 31'd1040, 31'd1077);
                5: load_settings(31'h0000_0001, 32'h0000_0000, 31'h0000_8000, 31'd5, 31'd900,
                                 31'd2, 31'd9);
                6: load_settings(31'h0100_0000, $urandom, 31'h0168_0000, 31'h7FFF_FFF0,
                                 31'h7FFF_FFF8, 31'h7FFF_FFFA, 31'h7FFF_FFFF);
                7: load_settings(31'($urandom), 32'h0000_0000, 31'h7FFF_FFFF, 31'd0, 31'd64,
                                 31'd0, 31'd0);
                default: load_settings(31'h0010_0000, $urandom, 31'($urandom), 31'd30,
                                       31'd31, 31'd31, 31'd33);
            endcase
            test_random_phase(185, ph == 2 || ph == 7);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        w_base = 0; w_ref = 0; w_period = 0; w_start = 0; w_ramp = 0; w_fade = 0; w_stop = 0;
        error_count = 0;
        cycle_count = 0;
        sent_count = 0;
        result_count = 0;
        active_count = 0;
        idle_mode = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        $display("covered %0d atom transfers, %0d results, %0d inside the restraint window",
                 sent_count, result_count, active_count);
        $display("window edges, ramps, fades and wrapping checked under twelve register settings");
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
